FILE: hw/rtl/tilde_escape_decoder_macros.svh
// Assertion macros shared by the tilde escape decoder RTL.
`ifndef TILDE_ESCAPE_DECODER_MACROS_SVH
`define TILDE_ESCAPE_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies another in the same cycle.
`define TED_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Check that a condition implies another in the following cycle.
`define TED_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define TED_ASSERT_SAME(label, cond, prop, msg)
`define TED_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

FILE: hw/rtl/ted_pkg.sv
// Types, constants and helper functions of the tilde escape decoder.
package ted_pkg;

    localparam logic [7:0] ESC_MARK = 8'h7E;
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Results of one decoded item: count in use, earliest in slot 0
    typedef struct packed {
        logic [1:0]                        count;
        out_item_t [MAX_RESULTS-1:0]       item;
    } dec_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Classify a byte as a hex digit, either case, and give its value
    function automatic hex_t hex_of(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = 4'(b - 8'h61 + 8'd10);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = 4'(b - 8'h41 + 8'd10);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: hw/rtl/ted_decode.sv
// Escape decoder: held state and the per-item decode into up to three results.
module ted_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  ted_pkg::in_item_t   item,
    input  logic                take,
    output ted_pkg::dec_result_t result
);

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_MARK  = 2'd1,
        HELD_DIGIT = 2'd2
    } held_t;

    held_t      held_reg;
    held_t      held_next;
    logic [7:0] held_digit_reg;
    logic [7:0] held_digit_next;

    ted_pkg::hex_t hex_in;
    ted_pkg::hex_t hex_held;
    logic          fresh_hold;

    assign hex_in     = ted_pkg::hex_of(item.in_byte);
    assign hex_held   = ted_pkg::hex_of(held_digit_reg);
    assign fresh_hold = (item.in_byte == ted_pkg::ESC_MARK) && !item.in_last;

    // Decode one item against what is held
    always_comb
    begin
        result          = '0;
        held_next       = held_reg;
        held_digit_next = held_digit_reg;
        unique case (held_reg)
            HELD_MARK:
            begin
                if (hex_in.valid)
                begin
                    if (item.in_last)
                    begin
                        result.count   = 2'd2;
                        result.item[0] = '{ted_pkg::ESC_MARK, 1'b0};
                        result.item[1] = '{item.in_byte, 1'b1};
                        held_next      = HELD_NONE;
                    end
                    else
                    begin
                        held_next       = HELD_DIGIT;
                        held_digit_next = item.in_byte;
                    end
                end
                else
                begin
                    result.item[0] = '{ted_pkg::ESC_MARK, 1'b0};
                    if (fresh_hold)
                    begin
                        result.count = 2'd1;
                        held_next    = HELD_MARK;
                    end
                    else
                    begin
                        result.count   = 2'd2;
                        result.item[1] = '{item.in_byte, item.in_last};
                        held_next      = HELD_NONE;
                    end
                end
            end
            HELD_DIGIT:
            begin
                if (hex_in.valid)
                begin
                    result.count   = 2'd1;
                    result.item[0] = '{{hex_held.value, hex_in.value}, item.in_last};
                    held_next      = HELD_NONE;
                end
                else
                begin
                    result.item[0] = '{ted_pkg::ESC_MARK, 1'b0};
                    result.item[1] = '{held_digit_reg, 1'b0};
                    if (fresh_hold)
                    begin
                        result.count = 2'd2;
                        held_next    = HELD_MARK;
                    end
                    else
                    begin
                        result.count   = 2'd3;
                        result.item[2] = '{item.in_byte, item.in_last};
                        held_next      = HELD_NONE;
                    end
                end
            end
            default:
            begin
                if (fresh_hold)
                begin
                    held_next = HELD_MARK;
                end
                else
                begin
                    result.count   = 2'd1;
                    result.item[0] = '{item.in_byte, item.in_last};
                    held_next      = HELD_NONE;
                end
            end
        endcase
    end

    // Advance the held state when the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= HELD_NONE;
        end
        else if (take)
        begin
            held_reg <= held_next;
        end
    end

    // Hold the first hex digit of an open escape
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_digit_reg <= held_digit_next;
        end
    end

endmodule

FILE: hw/rtl/ted_out_buffer.sv
// Result buffer: holds up to three decoded bytes and drains one per cycle while out_stall is low.
module ted_out_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ted_pkg::dec_result_t result,
    output logic                 ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ted_pkg::out_item_t   out_data
);

    logic [1:0]                                  count_reg;
    logic [1:0]                                  count_next;
    ted_pkg::out_item_t [ted_pkg::MAX_RESULTS-1:0] entry_reg;
    logic                                        pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[0];
    assign pop       = out_valid && !out_stall;
    // Room for a new set when empty, or once the last waiting byte leaves this cycle
    assign ready     = (count_reg == 2'd0) || ((count_reg == 2'd1) && !out_stall);

    always_comb
    begin
        if (load)
        begin
            count_next = result.count;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Track how many bytes wait
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Load a new set, or shift the queue forward on each pop
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= result.item;
        end
        else if (pop)
        begin
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

endmodule

FILE: hw/rtl/tilde_escape_decoder.sv
// Top level of the tilde escape decoder: input register, decoder, result buffer.
//
// Usage: feed the bytes of an escaped name on the in channel, one byte per
// item, with in_last set on the final byte. The out channel returns the
// decoded bytes, out_last set on the final byte of the name. "~HH" (two hex
// digits, either case) becomes one byte; a tilde without two hex digits, or
// near the end of the name, passes through raw.
// Both channels use valid/stall; an item moves when valid is high and stall
// low. An accepted byte waits in the input register until the result buffer
// can load its decoded set; the buffer then offers those results in order.
// Throughput: one item per cycle while items give at most one result each and the receiver does not stall.
// An item that flushes held bytes can give two or three results, and the single
// output port sets the rate: it gives the results out one by one, and the input
// stalls until the result buffer is down to its last byte.
// Reset clears the input register, the held escape and the result buffer.
// When the receiver stalls, the offered result holds and the input register
// stalls once it has a decoded set waiting.
`include "tilde_escape_decoder_macros.svh"

module tilde_escape_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ted_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ted_pkg::out_item_t out_data
);

    logic                 in_valid_reg;
    ted_pkg::in_item_t    in_item_reg;
    logic                 buf_ready;
    logic                 take;
    ted_pkg::dec_result_t dec_result;

    assign take     = in_valid_reg && buf_ready;
    assign in_stall = in_valid_reg && !buf_ready;

    // Hold the input item until the buffer takes its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

    ted_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_item_reg),
        .take   (take),
        .result (dec_result)
    );

    ted_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (dec_result),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A decoded set with results is offered in the next cycle
    `TED_ASSERT_NEXT(a_result_offered, take && (dec_result.count != 2'd0), out_valid, "decoded results not offered")
    // Only the final result of a set may carry the end mark
    `TED_ASSERT_SAME(a_last_at_end, take && (dec_result.count >= 2'd2), !dec_result.item[0].out_last, "end mark before final result")
    // Never stall with an empty input register
    `TED_ASSERT_SAME(a_stall_needs_item, in_stall, in_valid_reg, "stall without a held item")

endmodule

FILE: tb/tilde_escape_decoder_checker.sv
// Checker for the tilde escape decoder: predicts decoded bytes and compares them.
`timescale 1ns / 100ps

module tilde_escape_decoder_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ted_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ted_pkg::out_item_t out_data,
    output int unsigned        error_count,
    output int unsigned        bytes_taken,
    output int unsigned        bytes_decoded,
    output int unsigned        names_done,
    output int unsigned        bytes_awaited
);

    // Escape state of the prediction: 0 nothing held, 1 tilde, 2 tilde and digit
    logic [1:0]         held_count;
    logic [7:0]         held_digit;
    ted_pkg::out_item_t decoded_q[$];

    // Give the value of a hex digit, or -1 for any other byte
    function automatic int digit_value(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b) - 'h30;
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b) - 'h61 + 10;
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b) - 'h41 + 10;
        end
        return -1;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        ted_pkg::out_item_t r;
        r.out_byte = b;
        r.out_last = last;
        decoded_q = {decoded_q, r};
    endtask

    // Take a byte with nothing held: a tilde opens an escape unless it ends the name
    task automatic take_plain(input logic [7:0] b, input logic last);
        if (b == ted_pkg::ESC_MARK && !last)
        begin
            held_count = 2'd1;
        end
        else
        begin
            held_count = 2'd0;
            queue_byte(b, last);
        end
    endtask

    // Advance the escape state by one input byte and queue what it yields
    task automatic decode_byte(input ted_pkg::in_item_t it);
        logic [7:0] b;
        logic       last;
        int         lo;
        int         hi;
        b    = it.in_byte;
        last = it.in_last;
        lo   = digit_value(b);
        case (held_count)
            2'd1:
            begin
                if (lo >= 0 && last)
                begin
                    held_count = 2'd0;
                    queue_byte(ted_pkg::ESC_MARK, 1'b0);
                    queue_byte(b, 1'b1);
                end
                else if (lo >= 0)
                begin
                    held_count = 2'd2;
                    held_digit = b;
                end
                else
                begin
                    queue_byte(ted_pkg::ESC_MARK, 1'b0);
                    take_plain(b, last);
                end
            end
            2'd2:
            begin
                if (lo >= 0)
                begin
                    hi = digit_value(held_digit);
                    held_count = 2'd0;
                    queue_byte({hi[3:0], lo[3:0]}, last);
                end
                else
                begin
                    queue_byte(ted_pkg::ESC_MARK, 1'b0);
                    queue_byte(held_digit, 1'b0);
                    take_plain(b, last);
                end
            end
            default:
            begin
                take_plain(b, last);
            end
        endcase
    endtask

    // Compare one accepted result with the oldest expected byte
    task automatic check_result(input ted_pkg::out_item_t got);
        ted_pkg::out_item_t want;
        bytes_decoded++;
        if (got.out_last)
        begin
            names_done++;
        end
        if (decoded_q.size() == 0)
        begin
            $error("unexpected result: out_byte %h out_last %b", got.out_byte, got.out_last);
            error_count++;
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                error_count++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last: expected %b, actual %b", want.out_last, got.out_last);
                error_count++;
            end
        end
    endtask

    // Watch both channels; inputs are predicted before outputs are compared
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 2'd0;
            held_digit = 8'd0;
            decoded_q.delete();
            error_count   = 0;
            bytes_taken   = 0;
            bytes_decoded = 0;
            names_done    = 0;
            bytes_awaited = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_data);
                bytes_taken++;
            end
            if (out_valid && !out_stall)
            begin
                check_result(out_data);
            end
            bytes_awaited = decoded_q.size();
        end
    end

endmodule

FILE: tb/tb_tilde_escape_decoder.sv
// Testbench top for the tilde escape decoder: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_tilde_escape_decoder;

    localparam int unsigned RANDOM_ITEMS    = 430;
    localparam int unsigned CALM_ITEMS      = 60;
    localparam int unsigned HOLD_OFF_AFTER  = 60;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ted_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    ted_pkg::out_item_t out_data;

    bit          calm = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count;
    int unsigned bytes_taken;
    int unsigned bytes_decoded;
    int unsigned names_done;
    int unsigned bytes_awaited;

    tilde_escape_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    tilde_escape_decoder_checker decode_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .error_count   (error_count),
        .bytes_taken   (bytes_taken),
        .bytes_decoded (bytes_decoded),
        .names_done    (names_done),
        .bytes_awaited (bytes_awaited)
    );

    always #5 clk = ~clk;

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none in the calm tail
    initial
    begin
        int unsigned stall_left;
        bit          held_off;
        stall_left = 0;
        held_off   = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!held_off && bytes_taken >= HOLD_OFF_AFTER)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item, maybe after an idle burst, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        in_data.in_byte <= b;
        in_data.in_last <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Send a whole name, last mark on its final byte
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
    endfunction

    initial
    begin
        logic [7:0]  name[$];
        int unsigned name_len;
        int unsigned sent;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: escapes in both cases, broken escapes, tildes near the end
        send_text("~00z");
        send_text("~Ff");
        send_text("~~41");
        send_text("~4g");
        send_text("~4");
        send_text("~");
        send_text("~x");
        send_text("~9~");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Random names: mostly escapes and tildes with random content
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            name_len = $urandom_range(1, 10);
            name.delete();
            while (name.size() < name_len)
            begin
                case ($urandom_range(0, 9)) inside
                    [0:3]:
                    begin
                        name = {name, ted_pkg::ESC_MARK, hex_char(), hex_char()};
                    end
                    [4:5]:   name = {name, ted_pkg::ESC_MARK};
                    [6:7]:   name = {name, hex_char()};
                    8:       name = {name, 8'($urandom_range(0, 255))};
                    default: name = {name, 8'h67 + 8'($urandom_range(0, 19))};
                endcase
            end
            // Truncate so escapes are also cut short at the end of a name
            while (name.size() > name_len)
            begin
                name.delete(name.size() - 1);
            end
            if (sent + CALM_ITEMS >= RANDOM_ITEMS)
            begin
                calm = 1'b1;
            end
            foreach (name[i])
            begin
                send_byte(name[i], i == name.size() - 1);
            end
            sent += name.size();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain: wait for every expected byte, then a few more cycles
        while (bytes_awaited != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d input bytes and %0d decoded bytes over %0d names,",
                 bytes_taken, bytes_decoded, names_done);
        $display("with random stalls on both sides and one %0d-cycle receiver hold-off.",
                 HOLD_OFF_CYCLES);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
